// ===== src/third_order_state_space_euler_sim_assert.svh =====
// Assertion macros used by the plant simulator top level.
`ifndef THIRD_ORDER_STATE_SPACE_EULER_SIM_ASSERT_SVH
`define THIRD_ORDER_STATE_SPACE_EULER_SIM_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TOSSIM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TOSSIM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tossim_pkg.sv =====
// Shared types, constants, microcode ROM and saturation helper of the plant simulator.
package tossim_pkg;

    localparam int DATA_W    = 32;
    localparam int DT_W      = 16;
    localparam int DLY_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    localparam logic [DT_W-1:0] DT_RESET = 16'd655;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A0    = 3'd0,
        CFG_A1    = 3'd1,
        CFG_A2    = 3'd2,
        CFG_DT    = 3'd3,
        CFG_DELAY = 3'd4
    } cfg_idx_t;

    // Multiplier operand A sources
    typedef enum logic [3:0] {
        MA_ZERO,
        MA_A0,
        MA_A1,
        MA_A2,
        MA_VEL_HI,
        MA_VEL_LO,
        MA_ACC_HI,
        MA_ACC_LO,
        MA_DER_HI,
        MA_DER_LO
    } mul_a_t;

    // Multiplier operand B sources
    typedef enum logic [2:0] {
        MB_ZERO,
        MB_POS,
        MB_VEL,
        MB_ACC,
        MB_A1,
        MB_DT
    } mul_b_t;

    // Accumulator operations on the product register
    typedef enum logic [2:0] {
        AL_NONE,
        AL_STAB,
        AL_DINIT,
        AL_DSUB,
        AL_DSUBU,
        AL_SCHI,
        AL_SCLO
    } alu_op_t;

    // State register operations
    typedef enum logic [2:0] {
        S_NONE,
        S_START,
        S_POS,
        S_VEL,
        S_ACC,
        S_CLEAR
    } st_op_t;

    // Delay line port operations
    typedef enum logic [1:0] {
        M_NONE,
        M_WR,
        M_RD
    } mem_op_t;

    // Sequencer flow
    typedef enum logic [1:0] {
        Q_NEXT,
        Q_JCLR,
        Q_DONE
    } seq_op_t;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } seq_state_t;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_CLR = 4'd13;

    typedef struct packed {
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        alu_op_t alu_op;
        st_op_t  st_op;
        mem_op_t mem_op;
        seq_op_t seq_op;
        step_t   target;
    } ucode_t;

    localparam ucode_t UC_NOP = '{
        mul_a:  MA_ZERO,
        mul_b:  MB_ZERO,
        alu_op: AL_NONE,
        st_op:  S_NONE,
        mem_op: M_NONE,
        seq_op: Q_DONE,
        target: 4'd0
    };

    // Datapath to sequencer
    typedef struct packed {
        logic in_fire;
        logic act;
        logic out_free;
    } seq_in_t;

    // Sequencer to datapath
    typedef struct packed {
        ucode_t cw;
        logic   in_ready;
        logic   load_out;
    } seq_out_t;

    // Delay line strobes
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } dl_ctrl_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    localparam logic signed [DATA_W:0] SAT_HI = 33'sd2147483647;
    localparam logic signed [DATA_W:0] SAT_LO = -33'sd2147483648;

    // Clip a 65-bit sum to the signed 32-bit range
    function automatic sat_t sat32(input logic signed [64:0] v);
        sat_t r;
        r.hit = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > 65'(SAT_HI)) begin
            r.hit = 1'b1;
            r.val = SAT_HI[DATA_W-1:0];
        end else if (v < 65'(SAT_LO)) begin
            r.hit = 1'b1;
            r.val = SAT_LO[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic ucode_t uc(input mul_a_t ma, input mul_b_t mb, input alu_op_t al,
                                  input st_op_t so, input mem_op_t mo, input seq_op_t qo,
                                  input step_t tg);
        ucode_t w;
        w.mul_a  = ma;
        w.mul_b  = mb;
        w.alu_op = al;
        w.st_op  = so;
        w.mem_op = mo;
        w.seq_op = qo;
        w.target = tg;
        return w;
    endfunction

    // Microprogram. The product register holds the product of the operands selected on the step before.
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = UC_NOP;
        case (s)
            // a2*a1 for the stability test; branch off for a reset item
            4'd0:  w = uc(MA_A2,     MB_A1,   AL_NONE,  S_START, M_NONE, Q_JCLR, STEP_CLR);
            4'd1:  w = uc(MA_A0,     MB_POS,  AL_STAB,  S_NONE,  M_WR,   Q_NEXT, 4'd0);
            4'd2:  w = uc(MA_A1,     MB_VEL,  AL_DINIT, S_NONE,  M_RD,   Q_NEXT, 4'd0);
            4'd3:  w = uc(MA_A2,     MB_ACC,  AL_DSUBU, S_NONE,  M_NONE, Q_NEXT, 4'd0);
            4'd4:  w = uc(MA_VEL_HI, MB_DT,   AL_DSUB,  S_NONE,  M_NONE, Q_NEXT, 4'd0);
            4'd5:  w = uc(MA_VEL_LO, MB_DT,   AL_SCHI,  S_NONE,  M_NONE, Q_NEXT, 4'd0);
            4'd6:  w = uc(MA_ACC_HI, MB_DT,   AL_SCLO,  S_NONE,  M_NONE, Q_NEXT, 4'd0);
            4'd7:  w = uc(MA_ACC_LO, MB_DT,   AL_SCHI,  S_POS,   M_NONE, Q_NEXT, 4'd0);
            4'd8:  w = uc(MA_DER_HI, MB_DT,   AL_SCLO,  S_NONE,  M_NONE, Q_NEXT, 4'd0);
            4'd9:  w = uc(MA_DER_LO, MB_DT,   AL_SCHI,  S_VEL,   M_NONE, Q_NEXT, 4'd0);
            4'd10: w = uc(MA_ZERO,   MB_ZERO, AL_SCLO,  S_NONE,  M_NONE, Q_NEXT, 4'd0);
            4'd11: w = uc(MA_ZERO,   MB_ZERO, AL_NONE,  S_ACC,   M_NONE, Q_NEXT, 4'd0);
            4'd12: w = uc(MA_ZERO,   MB_ZERO, AL_NONE,  S_NONE,  M_NONE, Q_DONE, 4'd0);
            // reset item: flag, clear, report
            4'd13: w = uc(MA_ZERO,   MB_ZERO, AL_STAB,  S_CLEAR, M_NONE, Q_NEXT, 4'd0);
            4'd14: w = uc(MA_ZERO,   MB_ZERO, AL_NONE,  S_NONE,  M_NONE, Q_DONE, 4'd0);
            default: w = UC_NOP;
        endcase
        return w;
    endfunction

endpackage

// ===== src/tossim_ifs.sv =====
// Handshake channel interfaces for step items and result items.
interface tossim_step_if;
    import tossim_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, output action, output sample, input ready);
    modport sink (input valid, input action, input sample, output ready);
endinterface

interface tossim_res_if;
    import tossim_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] plant_out;
    logic                     saturated;
    logic                     stable;

    modport source (output valid, output plant_out, output saturated, output stable,
                    input ready);
    modport sink (input valid, input plant_out, input saturated, input stable,
                  output ready);
endinterface

// ===== src/third_order_state_space_euler_sim.sv =====
// Top level of the third-order plant simulator with dead time (Q16.16, forward Euler).
//
// Channels: step_ch carries items {action, sample}; action 0 advances the plant
// one Euler step driven by the sample from delay_steps items back (zero while
// fewer items have arrived since the last clear), action 1 clears the states and
// the delay line. res_ch returns one item {plant_out, saturated, stable} per input.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user must
// write it only while no item is in flight, the block itself does not enforce this.
// Timing: a step item runs through the main microprogram and a clear item through
// the short reset sequence; the result is registered in the output register as the
// sequencer returns to idle, and only then is the next item taken. The pace is
// set by the single shared 33x33 multiplier, which forms ten products per step.
// Reset: states, write pointer and fill count are cleared at once (no sweep of
// the delay memory); coefficients go to 0, time_step to 655, delay_steps to 0.
// Stall: the result waits in the output register; the sequencer holds on its
// last step until that register is free, and takes no new item meanwhile.
`include "third_order_state_space_euler_sim_assert.svh"

module third_order_state_space_euler_sim #(
    parameter int DELAY_DEPTH = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    tossim_step_if.sink                      step_ch,
    tossim_res_if.source                     res_ch,
    input  logic                             cfg_we,
    input  logic [tossim_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tossim_pkg::DATA_W-1:0]    cfg_data
);
    import tossim_pkg::*;

    // Configuration registers
    logic signed [DATA_W-1:0] a0_reg, a1_reg, a2_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [DLY_W-1:0]         dly_reg;

    // Captured item
    logic                     act_reg;
    logic signed [DATA_W-1:0] smp_reg;

    // Datapath registers
    logic signed [63:0]       prod_reg, prod_next;
    logic signed [63:0]       der_reg, der_next;
    logic signed [63:0]       tmp_reg, tmp_next;
    logic                     stab_reg, stab_next;
    logic signed [DATA_W-1:0] pos_reg, pos_next;
    logic signed [DATA_W-1:0] vel_reg, vel_next;
    logic signed [DATA_W-1:0] acc_reg, acc_next;
    logic                     hit_reg, hit_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_pos_reg;
    logic                     out_sat_reg;
    logic                     out_stab_reg;

    logic                     in_fire;
    seq_in_t                  si;
    seq_out_t                 sq;
    ucode_t                   cw;
    dl_ctrl_t                 dl_ctrl;
    logic signed [DATA_W-1:0] u_val;
    logic signed [63:0]       u_ext;

    logic signed [63:0]       src64;
    logic signed [DATA_W:0]   opa, opb;
    logic signed [65:0]       mul_full;
    logic signed [63:0]       prod_sh;
    logic signed [65:0]       a0_ext, stab_diff;
    logic                     stab_now;
    logic signed [DATA_W-1:0] old_sel;
    logic signed [64:0]       upd_sum;
    sat_t                     upd_sat;

    assign cw      = sq.cw;
    assign in_fire = step_ch.valid && step_ch.ready;
    assign step_ch.ready = sq.in_ready;

    // Sequencer
    assign si.in_fire  = in_fire;
    assign si.act      = act_reg;
    assign si.out_free = !out_valid_reg || res_ch.ready;

    tossim_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .si    (si),
        .so    (sq)
    );

    // Dead-time line
    assign dl_ctrl.wr_en = (cw.mem_op == M_WR);
    assign dl_ctrl.rd_en = (cw.mem_op == M_RD);
    assign dl_ctrl.clear = (cw.st_op == S_CLEAR);

    tossim_dline #(
        .DEPTH (DELAY_DEPTH)
    ) u_dline (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (dl_ctrl),
        .wr_data (smp_reg),
        .delay   (dly_reg),
        .rd_data (u_val)
    );

    assign u_ext = {{(64 - DATA_W){u_val[DATA_W-1]}}, u_val};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a0_reg  <= '0;
            a1_reg  <= '0;
            a2_reg  <= '0;
            dt_reg  <= DT_RESET;
            dly_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_A0:    a0_reg  <= cfg_data;
                CFG_A1:    a1_reg  <= cfg_data;
                CFG_A2:    a2_reg  <= cfg_data;
                CFG_DT:    dt_reg  <= cfg_data[DT_W-1:0];
                CFG_DELAY: dly_reg <= cfg_data[DLY_W-1:0];
                default:   ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= step_ch.action;
            smp_reg <= step_ch.sample;
        end
    end

    // Multiplier operands; scaled values split into signed high and unsigned low words
    always_comb
    begin
        case (cw.mul_a)
            MA_VEL_HI, MA_VEL_LO: src64 = {{(64 - DATA_W){vel_reg[DATA_W-1]}}, vel_reg};
            MA_ACC_HI, MA_ACC_LO: src64 = {{(64 - DATA_W){acc_reg[DATA_W-1]}}, acc_reg};
            MA_DER_HI, MA_DER_LO: src64 = der_reg;
            default:              src64 = '0;
        endcase

        case (cw.mul_a)
            MA_A0:                           opa = {a0_reg[DATA_W-1], a0_reg};
            MA_A1:                           opa = {a1_reg[DATA_W-1], a1_reg};
            MA_A2:                           opa = {a2_reg[DATA_W-1], a2_reg};
            MA_VEL_HI, MA_ACC_HI, MA_DER_HI: opa = {src64[63], src64[63:32]};
            MA_VEL_LO, MA_ACC_LO, MA_DER_LO: opa = {1'b0, src64[31:0]};
            default:                         opa = '0;
        endcase

        case (cw.mul_b)
            MB_POS:  opb = {pos_reg[DATA_W-1], pos_reg};
            MB_VEL:  opb = {vel_reg[DATA_W-1], vel_reg};
            MB_ACC:  opb = {acc_reg[DATA_W-1], acc_reg};
            MB_A1:   opb = {a1_reg[DATA_W-1], a1_reg};
            MB_DT:   opb = {{(DATA_W + 1 - DT_W){1'b0}}, dt_reg};
            default: opb = '0;
        endcase
    end

    assign mul_full  = opa * opb;
    assign prod_next = mul_full[63:0];

    // Floor-shifted product and Hurwitz test on a2*a1 - a0*2^F
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign a0_ext    = {{(66 - DATA_W){a0_reg[DATA_W-1]}}, a0_reg};
    assign stab_diff = {{2{prod_reg[63]}}, prod_reg} - (a0_ext <<< FRAC_BITS);
    assign stab_now  = !a2_reg[DATA_W-1] && (a2_reg != '0) &&
                       !stab_diff[65] && (stab_diff != '0);

    // Accumulators: derivative of acc, and d*dt/2^16 built from two partial products
    always_comb
    begin
        der_next  = der_reg;
        tmp_next  = tmp_reg;
        stab_next = stab_reg;
        case (cw.alu_op)
            AL_STAB:  stab_next = stab_now;
            AL_DINIT: der_next  = -prod_sh;
            AL_DSUB:  der_next  = der_reg - prod_sh;
            AL_DSUBU: der_next  = der_reg - prod_sh + u_ext;
            AL_SCHI:  tmp_next  = prod_reg <<< DT_W;
            AL_SCLO:  tmp_next  = tmp_reg + (prod_reg >>> DT_W);
            default:  ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        der_reg  <= der_next;
        tmp_reg  <= tmp_next;
        stab_reg <= stab_next;
    end

    // State update with saturation
    always_comb
    begin
        case (cw.st_op)
            S_POS:   old_sel = pos_reg;
            S_VEL:   old_sel = vel_reg;
            default: old_sel = acc_reg;
        endcase
        upd_sum = {{(65 - DATA_W){old_sel[DATA_W-1]}}, old_sel} + {tmp_reg[63], tmp_reg};
        upd_sat = sat32(upd_sum);

        pos_next = pos_reg;
        vel_next = vel_reg;
        acc_next = acc_reg;
        hit_next = hit_reg;
        case (cw.st_op)
            S_START: hit_next = 1'b0;
            S_POS:
            begin
                pos_next = upd_sat.val;
                hit_next = hit_reg | upd_sat.hit;
            end
            S_VEL:
            begin
                vel_next = upd_sat.val;
                hit_next = hit_reg | upd_sat.hit;
            end
            S_ACC:
            begin
                acc_next = upd_sat.val;
                hit_next = hit_reg | upd_sat.hit;
            end
            S_CLEAR:
            begin
                pos_next = '0;
                vel_next = '0;
                acc_next = '0;
                hit_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
            acc_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            acc_reg <= acc_next;
            hit_reg <= hit_next;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (sq.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq.load_out)
        begin
            out_pos_reg  <= pos_reg;
            out_sat_reg  <= hit_reg;
            out_stab_reg <= stab_reg;
        end
    end

    assign res_ch.valid     = out_valid_reg;
    assign res_ch.plant_out = out_pos_reg;
    assign res_ch.saturated = out_sat_reg;
    assign res_ch.stable    = out_stab_reg;

    // Checks
    `TOSSIM_ASSERT_NEXT(a_busy_after_accept, in_fire, !step_ch.ready, "item taken while busy")
    `TOSSIM_ASSERT_NOW(a_no_result_overwrite, sq.load_out, !out_valid_reg || res_ch.ready, "result overwritten")
    `TOSSIM_ASSERT_NEXT(a_clear_result_zero, sq.load_out && act_reg, (out_pos_reg == '0) && !out_sat_reg, "clear item result not zero")

endmodule

// ===== src/tossim_seq.sv =====
// Microcode sequencer: step counter, control ROM and item handshake control.
module tossim_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  tossim_pkg::seq_in_t  si,
    output tossim_pkg::seq_out_t so
);
    import tossim_pkg::*;

    seq_state_t state_reg, state_next;
    step_t      step_reg, step_next;
    ucode_t     cw_rom;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next step, control word and handshake strobes
    always_comb
    begin
        cw_rom      = ucode_rom(step_reg);
        state_next  = state_reg;
        step_next   = step_reg;
        so.cw       = UC_NOP;
        so.in_ready = 1'b0;
        so.load_out = 1'b0;
        case (state_reg)
            SQ_IDLE:
            begin
                so.in_ready = 1'b1;
                if (si.in_fire)
                begin
                    state_next = SQ_RUN;
                    step_next  = '0;
                end
            end
            SQ_RUN:
            begin
                so.cw = cw_rom;
                case (cw_rom.seq_op)
                    Q_NEXT: step_next = step_reg + 1'b1;
                    Q_JCLR: step_next = si.act ? cw_rom.target : step_reg + 1'b1;
                    Q_DONE:
                    begin
                        // hold on the last step until the output register frees up
                        if (si.out_free)
                        begin
                            so.load_out = 1'b1;
                            state_next  = SQ_IDLE;
                        end
                    end
                    default: state_next = SQ_IDLE;
                endcase
            end
            default: state_next = SQ_IDLE;
        endcase
    end

endmodule

// ===== src/tossim_dline.sv =====
// Dead-time delay line: circular sample memory with a fill count for cleared reads.
module tossim_dline #(
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tossim_pkg::dl_ctrl_t                  ctrl,
    input  logic signed [tossim_pkg::DATA_W-1:0] wr_data,
    input  logic [tossim_pkg::DLY_W-1:0]          delay,
    output logic signed [tossim_pkg::DATA_W-1:0] rd_data
);
    import tossim_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CW    = ((PTR_W > DLY_W) ? PTR_W : DLY_W) + 2;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic             ok_reg, ok_next;
    logic [DATA_W-1:0] q_reg;
    logic             qok_reg;

    logic [CW-1:0] dcl;
    logic [CW-1:0] wp_w;
    logic [CW-1:0] rp_w;

    // Read address and valid flag for the item being written
    always_comb
    begin
        dcl  = (CW'(delay) > CW'(DEPTH - 1)) ? CW'(DEPTH - 1) : CW'(delay);
        wp_w = CW'(wp_reg);
        rp_w = (wp_w >= dcl) ? (wp_w - dcl) : (wp_w + CW'(DEPTH) - dcl);
        rp_next = rp_w[PTR_W-1:0];
        // an entry is live if it was written after the last clear
        ok_next = (dcl <= CW'(fill_reg));
    end

    // Write pointer and fill count
    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            wp_next   = '0;
            fill_next = '0;
        end
        else if (ctrl.wr_en)
        begin
            wp_next = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (fill_reg != PTR_W'(DEPTH - 1))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wp_reg   <= wp_next;
            fill_reg <= fill_next;
        end
    end

    // Memory port and registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wp_reg] <= wr_data;
            rp_reg      <= rp_next;
            ok_reg      <= ok_next;
        end
        if (ctrl.rd_en)
        begin
            q_reg   <= mem[rp_reg];
            qok_reg <= ok_reg;
        end
    end

    assign rd_data = qok_reg ? q_reg : '0;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the third-order Euler plant simulator with dead time.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tossim_pkg::*;

    localparam int DELAY_DEPTH = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 7;
    localparam int QUIET_FROM  = 6000;
    localparam int QUIET_TO    = 10000;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_LEN    = 400;

    localparam logic signed [95:0] Q_TOP = 96'sd2147483647;
    localparam logic signed [95:0] Q_BOT = -96'sd2147483648;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] sample;
    } step_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] plant_out;
        logic                     saturated;
        logic                     stable;
    } plant_result_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    cfg_idx_t cfg_index;
    logic [DATA_W-1:0] cfg_data;

    tossim_step_if step_ch ();
    tossim_res_if  res_ch ();

    third_order_state_space_euler_sim #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_ch   (step_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and the plant state
    logic signed [DATA_W-1:0] coef_a0, coef_a1, coef_a2;
    logic [DT_W-1:0]          time_step;
    logic [DLY_W-1:0]         delay_steps;
    logic signed [DATA_W-1:0] pos_q, vel_q, acc_q;
    logic signed [DATA_W-1:0] dead_line [0:DELAY_DEPTH-1];
    logic [DLY_W-1:0]         line_wr;

    step_item_t    pending_items[$];
    plant_result_t plant_results_due[$];

    int queued_count   = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int holdoff_left   = 0;
    bit holdoff_done   = 1'b0;
    bit quiet;

    assign quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] clip_q16(input logic signed [95:0] v,
                                                           inout logic hit);
        if (v > Q_TOP)
        begin
            hit = 1'b1;
            return Q_TOP[DATA_W-1:0];
        end
        if (v < Q_BOT)
        begin
            hit = 1'b1;
            return Q_BOT[DATA_W-1:0];
        end
        return v[DATA_W-1:0];
    endfunction

    task automatic clear_plant();
        pos_q   = '0;
        vel_q   = '0;
        acc_q   = '0;
        line_wr = '0;
        for (int i = 0; i < DELAY_DEPTH; i++)
            dead_line[i] = '0;
    endtask

    // One Euler step (or a clear) on the predictor; queues the expected result
    task automatic advance_plant(input logic act, input logic signed [DATA_W-1:0] smp);
        logic signed [95:0] a0w, a1w, a2w, dtw, pw, vw, aw, u, dacc;
        logic signed [95:0] npos, nvel, nacc;
        logic [DLY_W-1:0]   rd_idx;
        logic               hit;
        plant_result_t      res;
        a0w = coef_a0;
        a1w = coef_a1;
        a2w = coef_a2;
        dtw = {80'd0, time_step};
        hit = 1'b0;
        // Hurwitz test, exact
        res.stable = (a2w > 0) && ((a2w * a1w - (a0w <<< FRAC_BITS)) > 0);
        if (act)
        begin
            clear_plant();
            res.plant_out = '0;
            res.saturated = 1'b0;
        end
        else
        begin
            // dead time: write first, then read delay_steps back
            dead_line[line_wr] = smp;
            rd_idx  = line_wr - delay_steps;
            u       = dead_line[rd_idx];
            line_wr = line_wr + 1'b1;
            pw = pos_q;
            vw = vel_q;
            aw = acc_q;
            dacc = u - ((a0w * pw) >>> FRAC_BITS) - ((a1w * vw) >>> FRAC_BITS)
                     - ((a2w * aw) >>> FRAC_BITS);
            npos = pw + ((vw * dtw) >>> DT_W);
            nvel = vw + ((aw * dtw) >>> DT_W);
            nacc = aw + ((dacc * dtw) >>> DT_W);
            pos_q = clip_q16(npos, hit);
            vel_q = clip_q16(nvel, hit);
            acc_q = clip_q16(nacc, hit);
            res.plant_out = pos_q;
            res.saturated = hit;
        end
        plant_results_due.push_back(res);
    endtask

    // Step item driver
    always @(posedge clk)
    begin : step_driver
        step_item_t nxt;
        if (!rst_n)
            step_ch.valid <= 1'b0;
        else
        begin
            if (step_ch.valid && step_ch.ready)
            begin
                advance_plant(step_ch.action, step_ch.sample);
                accepted_count <= accepted_count + 1;
            end
            if (!step_ch.valid || step_ch.ready)
            begin
                if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = pending_items.pop_front();
                    step_ch.valid  <= 1'b1;
                    step_ch.action <= nxt.action;
                    step_ch.sample <= nxt.sample;
                end
                else
                    step_ch.valid <= 1'b0;
            end
        end
    end

    // Long output hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (!holdoff_done && accepted_count >= HOLD_AT)
        begin
            holdoff_left <= HOLD_LEN;
            holdoff_done <= 1'b1;
        end
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Result monitor and checker
    always @(posedge clk)
    begin : result_monitor
        plant_result_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (plant_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d %b %b",
                             $time, res_ch.plant_out, res_ch.saturated, res_ch.stable);
                    mismatch_count++;
                end
                else
                begin
                    want = plant_results_due.pop_front();
                    if (res_ch.plant_out !== want.plant_out)
                    begin
                        $display("%0t: plant_out mismatch, expected %0d, got %0d",
                                 $time, want.plant_out, res_ch.plant_out);
                        mismatch_count++;
                    end
                    if (res_ch.saturated !== want.saturated)
                    begin
                        $display("%0t: saturated mismatch, expected %b, got %b",
                                 $time, want.saturated, res_ch.saturated);
                        mismatch_count++;
                    end
                    if (res_ch.stable !== want.stable)
                    begin
                        $display("%0t: stable mismatch, expected %b, got %b",
                                 $time, want.stable, res_ch.stable);
                        mismatch_count++;
                    end
                end
            end
            res_ch.ready <= !(holdoff_left != 0 || (!quiet && $urandom_range(99) < IDLE_PCT));
        end
    end

    // Register write; the predictor copy follows at once since the block is idle
    task automatic write_reg(input cfg_idx_t idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_A0:    coef_a0 = val;
            CFG_A1:    coef_a1 = val;
            CFG_A2:    coef_a2 = val;
            CFG_DT:    time_step = val[DT_W-1:0];
            CFG_DELAY: delay_steps = val[DLY_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_plant(input logic [31:0] a0, input logic [31:0] a1,
                              input logic [31:0] a2, input logic [15:0] dt,
                              input logic [9:0] dly);
        write_reg(CFG_A0, a0);
        write_reg(CFG_A1, a1);
        write_reg(CFG_A2, a2);
        write_reg(CFG_DT, {16'd0, dt});
        write_reg(CFG_DELAY, {22'd0, dly});
        @(negedge clk);
    endtask

    function automatic void push_item(input logic act, input logic [31:0] smp);
        step_item_t it;
        it.action = act;
        it.sample = smp;
        pending_items.push_back(it);
        queued_count++;
    endfunction

    // Extremes, full range or a small value around the useful band
    function automatic logic [31:0] pick_coef(input bit wide);
        int unsigned r;
        r = $urandom_range(99);
        if (wide && r < 30)
        begin
            case ($urandom_range(4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0001_0000;
            endcase
        end
        if (wide && r < 60)
            return $urandom;
        return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0002_0000;
    endfunction

    function automatic logic [31:0] pick_sample(input int full_pct);
        if ($urandom_range(99) < full_pct)
            return $urandom;
        return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endfunction

    function automatic void queue_random(input int n, input int clear_pct, input int full_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < clear_pct)
                push_item(1'b1, pick_sample(100));
            else
                push_item(1'b0, pick_sample(full_pct));
        end
    endfunction

    // Every item in and every result out, then a short settle
    task automatic wait_drained();
        @(negedge clk);
        while (accepted_count != queued_count || plant_results_due.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_A0;
        cfg_data       = '0;
        step_ch.valid  = 1'b0;
        step_ch.action = 1'b0;
        step_ch.sample = '0;
        res_ch.ready   = 1'b0;
        coef_a0        = '0;
        coef_a1        = '0;
        coef_a2        = '0;
        time_step      = DT_RESET;
        delay_steps    = '0;
        clear_plant();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: sample extremes and a clear
        push_item(1'b0, 32'h7FFF_FFFF);
        push_item(1'b0, 32'h8000_0000);
        push_item(1'b0, 32'h0000_0000);
        push_item(1'b0, 32'hFFFF_FFFF);
        push_item(1'b0, 32'h0001_0000);
        push_item(1'b1, 32'h5555_AAAA);
        push_item(1'b0, 32'h1234_5678);
        wait_drained();

        // Coefficient and time step extremes: drives the states into saturation
        load_plant(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 10'd2);
        repeat (4) push_item(1'b0, 32'h7FFF_FFFF);
        push_item(1'b1, 32'h0000_0000);
        repeat (4) push_item(1'b0, 32'h8000_0000);
        wait_drained();

        // Zero time step holds the states; a2*a1 equal to a0 is not stable
        load_plant(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 16'h0000, 10'd1023);
        push_item(1'b0, 32'h7FFF_FFFF);
        push_item(1'b0, 32'h8000_0000);
        push_item(1'b0, 32'h0003_0000);
        push_item(1'b1, 32'hFFFF_FFFF);
        wait_drained();

        // Long run with no clear, dead time changed between settings, ending at full depth
        load_plant(32'h0001_0000, 32'h0003_0000, 32'h0003_0000, 16'd655, 10'd0);
        queue_random(100, 0, 5);
        wait_drained();
        load_plant(pick_coef(1'b0), pick_coef(1'b0), pick_coef(1'b0),
                   16'($urandom_range(0, 65535)), 10'($urandom_range(1, 60)));
        queue_random(100, 0, 5);
        wait_drained();
        load_plant(32'h0008_0000, 32'h000C_0000, 32'h0006_0000, 16'd3000, 10'd1023);
        queue_random(520, 0, 5);
        wait_drained();

        // Full-range coefficients at the largest step, frequent clears
        load_plant(pick_coef(1'b1), pick_coef(1'b1), pick_coef(1'b1), 16'hFFFF,
                   10'($urandom_range(0, 8)));
        queue_random(60, 10, 40);
        wait_drained();

        // Zero step with random coefficients
        load_plant(pick_coef(1'b1), pick_coef(1'b1), pick_coef(1'b1), 16'h0000,
                   10'($urandom_range(1, 5)));
        queue_random(25, 5, 30);
        wait_drained();

        // Everything random
        load_plant(pick_coef(1'b1), pick_coef(1'b1), pick_coef(1'b1),
                   16'($urandom_range(0, 65535)),
                   ($urandom_range(9) == 0) ? 10'($urandom_range(0, 1023))
                                            : 10'($urandom_range(0, 30)));
        queue_random(80, 5, 30);
        wait_drained();

        repeat (30) @(posedge clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/tossim_pkg.sv
src/tossim_ifs.sv
src/tossim_seq.sv
src/tossim_dline.sv
src/third_order_state_space_euler_sim.sv
tb/testbench.sv
